// ===== hw/rtl/injection_chain_tracker_assert.svh =====
// assertion macros shared by the tracker modules
// the enclosing module provides clk_i and rst_ni
`ifndef INJECTION_CHAIN_TRACKER_ASSERT_SVH
`define INJECTION_CHAIN_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define ICT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ICT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ICT_ASSERT(lbl, prop, msg)
`define ICT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/ict_pkg.sv =====
`timescale 1ns / 1ps

package ict_pkg;

  localparam int unsigned TABLE_SLOTS = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_SLOTS);
  localparam int unsigned SCAN_W      = $clog2(TABLE_SLOTS + 1);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned IN_W      = 160;
  localparam int unsigned OUT_W     = 104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_WINDOW   = 3'd1,
    CFG_OPEN     = 3'd2,
    CFG_PARTIAL  = 3'd3,
    CFG_COMPLETE = 3'd4
  } cfg_idx_e;

  localparam logic [31:0]      WINDOW_RST   = 32'd10000;
  localparam logic [31:0]      OPEN_RST     = 32'd1;
  localparam logic [CNT_W-1:0] PARTIAL_RST  = 6'd3;
  localparam logic [CNT_W-1:0] COMPLETE_RST = 6'd5;

  typedef struct packed {
    logic [31:0] caller;
    logic [31:0] target;
    logic [63:0] last_time;
    logic [31:0] mask;
    logic        psent;
    logic        csent;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic scan;
    logic merge;
    logic count;
    logic commit;
  } ict_cmd_t;

  typedef struct packed {
    logic ignore;
    logic scan_done;
    logic proceed;
    logic stall;
  } ict_stat_t;

  function automatic logic [CNT_W-1:0] popcount32(input logic [31:0] v);
    logic [CNT_W-1:0] sum;
    logic [2:0]       nib;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      nib = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
      sum = sum + CNT_W'(nib);
    end
    return sum;
  endfunction

endpackage

// ===== hw/rtl/ict_ram.sv =====
`timescale 1ns / 1ps

module ict_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/ict_ctrl.sv =====
`timescale 1ns / 1ps
`include "injection_chain_tracker_assert.svh"

module ict_ctrl import ict_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ict_stat_t stat_i,
  output ict_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_MERGE  = 5'b00100,
    ST_COUNT  = 5'b01000,
    ST_COMMIT = 5'b10000
  } ict_state_e;

  ict_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !stat_i.ignore) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        // no hit and not an opening stage: nothing to update
        state_d = stat_i.proceed ? ST_COUNT : ST_IDLE;
      end
      ST_COUNT: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat_i.stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.scan   = (state_q == ST_SCAN);
  assign cmd_o.merge  = (state_q == ST_MERGE);
  assign cmd_o.count  = (state_q == ST_COUNT);
  assign cmd_o.commit = (state_q == ST_COMMIT) && !stat_i.stall;

  `ICT_ASSERT(a_stall_holds, (state_q == ST_COMMIT && stat_i.stall) |=> (state_q == ST_COMMIT),
              "commit left while the result register was blocked")
  `ICT_ASSERT(a_scan_exit, (state_q == ST_SCAN && stat_i.scan_done) |=> (state_q == ST_MERGE),
              "scan did not hand over to merge")
  `ICT_ASSERT_ALWAYS(a_reset_idle, $rose(rst_ni) |-> (state_q == ST_IDLE && !cmd_o.commit),
                     "controller not idle out of reset")

endmodule

// ===== hw/rtl/ict_datapath.sv =====
`timescale 1ns / 1ps
`include "injection_chain_tracker_assert.svh"

module ict_datapath import ict_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [IN_W-1:0]      item_i,
  input  ict_cmd_t             cmd_i,
  output ict_stat_t            stat_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [OUT_W-1:0]     out_data_o,
  output logic                 out_kind_o
);

  // configuration
  logic             enable_q;
  logic [31:0]      window_q, open_q;
  logic [CNT_W-1:0] partial_q, complete_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      window_q   <= WINDOW_RST;
      open_q     <= OPEN_RST;
      partial_q  <= PARTIAL_RST;
      complete_q <= COMPLETE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:   enable_q   <= cfg_wdata_i[0];
        CFG_WINDOW:   window_q   <= cfg_wdata_i;
        CFG_OPEN:     open_q     <= cfg_wdata_i;
        CFG_PARTIAL:  partial_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_COMPLETE: complete_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // incoming item fields
  logic [31:0] in_caller, in_target, in_stage;
  logic [63:0] in_time;
  assign in_caller = item_i[31:0];
  assign in_target = item_i[63:32];
  assign in_stage  = item_i[95:64];
  assign in_time   = item_i[159:96];

  logic [31:0] caller_q, target_q, stage_q;
  logic [63:0] now_q;
  logic        is_open_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      caller_q  <= in_caller;
      target_q  <= in_target;
      stage_q   <= in_stage;
      now_q     <= in_time;
      is_open_q <= (in_stage == open_q);
    end
  end

  // entry table: payload in ram, valid bits in flops
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  logic [ENTRY_W-1:0]     ram_rdata, ram_wdata;
  entry_t                 rd, wr;

  // scan state
  logic [SCAN_W-1:0] scan_idx_q, scan_idx_d;
  logic              eval_vld_q, eval_vld_d;
  logic [IDX_W-1:0]  eval_idx_q, eval_idx_d;
  logic              found_q, found_d;
  logic              have_free_q, have_free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              have_old_q, have_old_d;
  logic [IDX_W-1:0]  old_idx_q, old_idx_d;
  logic [63:0]       old_time_q, old_time_d;

  // update state
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  entry_t            hit_q, hit_d;
  logic [31:0]       new_mask_q, new_mask_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic [31:0]       out_caller_q, out_caller_d;
  logic [31:0]       out_target_q, out_target_d;
  logic [31:0]       out_mask_q, out_mask_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic [63:0] age;
  logic        eval_live, expired, match;
  logic        fire_p, fire_c, fire;

  assign rd        = entry_t'(ram_rdata);
  assign eval_live = eval_vld_q && valid_q[eval_idx_q];
  assign age       = now_q - rd.last_time;
  assign expired   = age > {32'd0, window_q};
  assign match     = eval_live && !expired && (rd.caller == caller_q) &&
                     (!is_open_q || (rd.target == target_q));

  assign fire_p = (cnt_q >= partial_q) && !hit_q.psent;
  assign fire_c = (cnt_q >= complete_q) && !hit_q.csent;
  assign fire   = fire_p || fire_c;

  assign stat_o.ignore    = !enable_q || (in_caller == 32'd0) || (in_stage == 32'd0);
  assign stat_o.scan_done = eval_vld_q && (match || (eval_idx_q == LAST_IDX));
  assign stat_o.proceed   = found_q || is_open_q;
  assign stat_o.stall     = fire && out_valid_q && !out_ready_i;

  always_comb begin
    valid_d     = valid_q;
    scan_idx_d  = scan_idx_q;
    eval_vld_d  = 1'b0;
    eval_idx_d  = eval_idx_q;
    found_d     = found_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    have_old_d  = have_old_q;
    old_idx_d   = old_idx_q;
    old_time_d  = old_time_q;
    hit_idx_d   = hit_idx_q;
    hit_d       = hit_q;
    new_mask_d  = new_mask_q;
    cnt_d       = cnt_q;

    if (cmd_i.load) begin
      scan_idx_d  = '0;
      found_d     = 1'b0;
      have_free_d = 1'b0;
      have_old_d  = 1'b0;
    end else if (cmd_i.scan) begin
      // read of one entry issued while the previous one is judged
      if (scan_idx_q != SCAN_END) begin
        eval_vld_d = 1'b1;
        eval_idx_d = scan_idx_q[IDX_W-1:0];
        scan_idx_d = scan_idx_q + SCAN_W'(1);
      end
      if (eval_vld_q) begin
        if (!eval_live || expired) begin
          if (eval_live) valid_d[eval_idx_q] = 1'b0;
          if (!have_free_q) begin
            have_free_d = 1'b1;
            free_idx_d  = eval_idx_q;
          end
        end else if (match) begin
          found_d   = 1'b1;
          hit_idx_d = eval_idx_q;
          hit_d     = rd;
        end else if (!have_old_q || (rd.last_time < old_time_q)) begin
          have_old_d = 1'b1;
          old_idx_d  = eval_idx_q;
          old_time_d = rd.last_time;
        end
      end
    end

    if (cmd_i.merge) begin
      new_mask_d = (found_q ? hit_q.mask : 32'd0) | stage_q;
      if (!found_q) begin
        hit_idx_d = have_free_q ? free_idx_q : old_idx_q;
        hit_d     = '{caller: caller_q, target: target_q, last_time: 64'd0,
                      mask: 32'd0, psent: 1'b0, csent: 1'b0};
      end
    end

    if (cmd_i.count) begin
      cnt_d = popcount32(new_mask_q);
    end

    if (cmd_i.commit) begin
      valid_d[hit_idx_q] = 1'b1;
    end
  end

  assign wr = '{caller: hit_q.caller, target: hit_q.target, last_time: now_q,
                mask: new_mask_q, psent: hit_q.psent || fire_p,
                csent: hit_q.csent || fire_c};
  assign ram_wdata = ENTRY_W'(wr);

  ict_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(hit_idx_q),
    .wdata_i(ram_wdata),
    .raddr_i(scan_idx_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_caller_d = out_caller_q;
    out_target_d = out_target_q;
    out_mask_d   = out_mask_q;
    out_cnt_d    = out_cnt_q;
    if (cmd_i.commit && fire) begin
      // complete wins when both thresholds are crossed together
      out_valid_d  = 1'b1;
      out_kind_d   = fire_c;
      out_caller_d = hit_q.caller;
      out_target_d = hit_q.target;
      out_mask_d   = new_mask_q;
      out_cnt_d    = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      eval_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
      have_old_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      eval_vld_q  <= eval_vld_d;
      found_q     <= found_d;
      have_free_q <= have_free_d;
      have_old_q  <= have_old_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q   <= scan_idx_d;
    eval_idx_q   <= eval_idx_d;
    free_idx_q   <= free_idx_d;
    old_idx_q    <= old_idx_d;
    old_time_q   <= old_time_d;
    hit_idx_q    <= hit_idx_d;
    hit_q        <= hit_d;
    new_mask_q   <= new_mask_d;
    cnt_q        <= cnt_d;
    out_kind_q   <= out_kind_d;
    out_caller_q <= out_caller_d;
    out_target_q <= out_target_d;
    out_mask_q   <= out_mask_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = {2'b00, out_cnt_q, out_mask_q, out_target_q, out_caller_q};

  `ICT_ASSERT(a_no_overwrite, (cmd_i.commit && fire) |-> (!out_valid_q || out_ready_i),
              "pending result overwritten")
  `ICT_ASSERT(a_commit_valid, cmd_i.commit |=> valid_q[$past(hit_idx_q)],
              "committed entry not marked valid")

endmodule

// ===== hw/rtl/injection_chain_tracker.sv =====
`timescale 1ns / 1ps
// an item passes the scan and merge states, then count and commit if it updates a chain;
//   the scan stops at its chain's slot or runs through the whole table without a hit
// new items are taken only in idle; the scan reads one entry per cycle from the table ram,
//   and ignored items are dropped while the block stays idle
// an alert still waiting on the output holds the next alerting item in commit until it drains
// reset: clears every valid bit and loads the register defaults at once, no clearing pass

module injection_chain_tracker import ict_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // caller_pid, target_pid, stage_bits, time_ms
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // alert_caller, alert_target, alert_mask, alert_stage_count, 2 bits zero
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic [0:0]           m_axis_tuser   // alert_kind
);

  ict_cmd_t  cmd;
  ict_stat_t stat;

  ict_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ict_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (s_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_kind_o (m_axis_tuser[0])
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ict_pkg::*;

  // event layout on the input bus, lowest field last
  typedef struct packed {
    logic [63:0] time_ms;
    logic [31:0] stage;
    logic [31:0] target;
    logic [31:0] caller;
  } hook_event_t;

  // alert kind on top of the output bus layout
  typedef struct packed {
    logic        kind;
    logic [1:0]  pad;
    logic [5:0]  count;
    logic [31:0] mask;
    logic [31:0] target;
    logic [31:0] caller;
  } chain_alert_t;

  localparam int SETTLE_CYCLES = TABLE_SLOTS + 16;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;   // caller_pid, target_pid, stage_bits, time_ms
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // alert_caller, alert_target, alert_mask, alert_stage_count
  logic [0:0]           m_axis_tuser;   // alert_kind

  injection_chain_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // shadow of the tracker registers and chain table
  bit          cfg_enable;
  logic [31:0] cfg_window;
  logic [31:0] cfg_open;
  logic [5:0]  cfg_partial;
  logic [5:0]  cfg_complete;
  bit          chain_live [TABLE_SLOTS];
  entry_t      chains [TABLE_SLOTS];

  chain_alert_t alerts_due [$];
  int           bad_alerts;
  bit           quiet_mode;
  int           rx_hold_req;
  logic [63:0]  now_ms;
  logic [31:0]  chain_callers [48];
  logic [31:0]  chain_targets [4];

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void flag_alert(string what);
    bad_alerts++;
    if (bad_alerts <= 10) $display("%0t: %s", $time, what);
  endfunction

  // scan the table the way the block does and queue the alert, if any
  function automatic void track_event(hook_event_t ev);
    bit           is_open;
    bit           have_free;
    bit           have_old;
    bit           found;
    int unsigned  free_slot;
    int unsigned  old_slot;
    int unsigned  hit;
    logic [63:0]  old_time;
    logic [5:0]   cnt;
    bit           fire_p;
    bit           fire_c;
    chain_alert_t a;
    if (!cfg_enable || ev.caller == '0 || ev.stage == '0) return;
    is_open   = (ev.stage == cfg_open);
    have_free = 1'b0;
    have_old  = 1'b0;
    found     = 1'b0;
    free_slot = 0;
    old_slot  = 0;
    hit       = 0;
    old_time  = '0;
    for (int unsigned k = 0; k < TABLE_SLOTS; k++) begin
      if (!found) begin
        if (!chain_live[k]) begin
          if (!have_free) begin
            have_free = 1'b1;
            free_slot = k;
          end
        end else if (ev.time_ms - chains[k].last_time > 64'(cfg_window)) begin
          chain_live[k] = 1'b0;
          chains[k]     = '0;
          if (!have_free) begin
            have_free = 1'b1;
            free_slot = k;
          end
        end else if (chains[k].caller == ev.caller &&
                     (!is_open || chains[k].target == ev.target)) begin
          found = 1'b1;
          hit   = k;
        end else if (!have_old || chains[k].last_time < old_time) begin
          have_old = 1'b1;
          old_time = chains[k].last_time;
          old_slot = k;
        end
      end
    end
    if (!found) begin
      if (!is_open) return;
      // first free slot, else evict the stalest live chain
      hit = have_free ? free_slot : old_slot;
      chains[hit]        = '0;
      chain_live[hit]    = 1'b1;
      chains[hit].caller = ev.caller;
      chains[hit].target = ev.target;
    end
    chains[hit].mask      = chains[hit].mask | ev.stage;
    chains[hit].last_time = ev.time_ms;
    cnt    = 6'($countones(chains[hit].mask));
    fire_p = (cnt >= cfg_partial) && !chains[hit].psent;
    fire_c = (cnt >= cfg_complete) && !chains[hit].csent;
    if (fire_p) chains[hit].psent = 1'b1;
    if (fire_c) chains[hit].csent = 1'b1;
    if (!fire_p && !fire_c) return;
    a.kind   = fire_c;
    a.pad    = '0;
    a.count  = cnt;
    a.mask   = chains[hit].mask;
    a.target = chains[hit].target;
    a.caller = chains[hit].caller;
    alerts_due.push_back(a);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ENABLE:   cfg_enable   = val[0];
      CFG_WINDOW:   cfg_window   = val;
      CFG_OPEN:     cfg_open     = val;
      CFG_PARTIAL:  cfg_partial  = val[5:0];
      CFG_COMPLETE: cfg_complete = val[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // valid stays high after a handshake so back-to-back items need no toggle
  task automatic send_event(hook_event_t ev);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ev;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_event(ev);
  endtask

  // stop sending, let every alert arrive and the last scan finish
  task automatic wait_alerts_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (alerts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic hook_event_t draw_event(int pool_n, int still_pct);
    hook_event_t ev;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 2) now_ms = {$urandom, $urandom};
    else if (r < 6) now_ms = now_ms + 64'(cfg_window) + 64'($urandom_range(1, 3000));
    else if ($urandom_range(0, 99) >= still_pct) now_ms = now_ms + 64'($urandom_range(1, 300));
    ev.time_ms = now_ms;
    ev.caller  = chain_callers[$urandom_range(0, pool_n - 1)];
    ev.target  = chain_targets[$urandom_range(0, 3)];
    r = $urandom_range(0, 99);
    if (r < 30) begin
      ev.stage = cfg_open;
    end else if (r < 78) begin
      ev.stage = 32'd1 << $urandom_range(0, 7);
    end else if (r < 86) begin
      ev.stage = 32'd1 << $urandom_range(0, 31);
    end else if (r < 92) begin
      ev.stage = $urandom;
    end else if (r < 96) begin
      // stray chain with random ids
      ev.caller = $urandom;
      ev.target = $urandom;
      ev.stage  = cfg_open;
    end else if (r < 98) begin
      ev.caller = '0;
      ev.stage  = 32'd1 << $urandom_range(0, 31);
    end else begin
      ev.stage = '0;
    end
    return ev;
  endfunction

  task automatic run_random(int n_live, int pool_n, int still_pct, int hold_at, int pause_every);
    hook_event_t ev;
    int          live;
    bit          counted;
    live = 0;
    while (live < n_live) begin
      ev      = draw_event(pool_n, still_pct);
      counted = cfg_enable && ev.caller != '0 && ev.stage != '0;
      send_event(ev);
      if (counted) begin
        live++;
        if (live == hold_at) rx_hold_req = 400;
        if (pause_every > 0 && live % pause_every == 0) wait_alerts_drained();
      end
    end
    wait_alerts_drained();
  endtask

  task automatic test_chain_thresholds();
    send_event('{caller: 32'd5, target: 32'd7, stage: 32'd1, time_ms: 64'd100});
    wait_alerts_drained();
    write_reg(CFG_ENABLE, 32'd1);
    send_event('{caller: 32'd0, target: 32'd7, stage: 32'd1, time_ms: 64'd100});
    send_event('{caller: 32'd5, target: 32'd7, stage: 32'd0, time_ms: 64'd100});
    send_event('{caller: 32'd5, target: 32'd7, stage: 32'd2, time_ms: 64'd100});
    // chain opened just below the top of the time range, then time wraps
    send_event('{caller: '1, target: '1, stage: 32'd1, time_ms: 64'hFFFF_FFFF_FFFF_FF00});
    send_event('{caller: '1, target: 32'd0, stage: 32'd6, time_ms: 64'h10});
    send_event('{caller: '1, target: 32'd0, stage: 32'h18, time_ms: 64'h20});
    send_event('{caller: '1, target: 32'd0, stage: '1, time_ms: 64'h30});
    send_event('{caller: '1, target: 32'd0, stage: 32'd2, time_ms: 64'd20048});
    send_event('{caller: 32'hA5A5A5A5, target: 32'h5A5A5A5A, stage: 32'd1,
                 time_ms: 64'd20048});
    wait_alerts_drained();
  endtask

  task automatic test_both_at_once();
    write_reg(CFG_PARTIAL, 32'd2);
    write_reg(CFG_COMPLETE, 32'd2);
    write_reg(CFG_WINDOW, 32'd0);
    send_event('{caller: 32'h12345678, target: 32'd9, stage: 32'd1, time_ms: 64'd20048});
    send_event('{caller: 32'h12345678, target: 32'd0, stage: 32'd4, time_ms: 64'd20048});
    send_event('{caller: 32'h12345678, target: 32'd9, stage: 32'd8, time_ms: 64'd20049});
    wait_alerts_drained();
  endtask

  task automatic test_threshold_extremes();
    write_reg(CFG_OPEN, '1);
    write_reg(CFG_PARTIAL, 32'd0);
    write_reg(CFG_COMPLETE, 32'd33);
    write_reg(CFG_WINDOW, '1);
    send_event('{caller: 32'd3, target: 32'd4, stage: '1, time_ms: 64'd0});
    send_event('{caller: 32'd3, target: 32'd4, stage: 32'd1, time_ms: 64'd1});
    send_event('{caller: 32'd3, target: 32'd5, stage: '1, time_ms: 64'd2});
    wait_alerts_drained();
    write_reg(CFG_OPEN, 32'd0);
    write_reg(CFG_PARTIAL, 32'd63);
    write_reg(CFG_COMPLETE, 32'd0);
    send_event('{caller: 32'd3, target: 32'd9, stage: 32'd2, time_ms: 64'd3});
    send_event('{caller: 32'd3, target: 32'd9, stage: 32'd0, time_ms: 64'd4});
    send_event('{caller: 32'd3, target: 32'd9, stage: 32'd1, time_ms: 64'd5});
    wait_alerts_drained();
  endtask

  task automatic test_random_default();
    write_reg(CFG_WINDOW, 32'd3000);
    write_reg(CFG_OPEN, 32'd1);
    write_reg(CFG_PARTIAL, 32'd3);
    write_reg(CFG_COMPLETE, 32'd5);
    now_ms = 64'd50000;
    // long receiver hold part way through so the block backs up
    run_random(500, 12, 10, 120, 0);
  endtask

  task automatic test_random_crowded_table();
    write_reg(CFG_WINDOW, 32'd60000);
    write_reg(CFG_OPEN, 32'h8000_0000);
    write_reg(CFG_PARTIAL, 32'd2);
    write_reg(CFG_COMPLETE, 32'd4);
    // many callers and frequent equal timestamps exercise eviction ties
    run_random(500, 48, 40, 0, 150);
  endtask

  task automatic test_random_no_idle();
    write_reg(CFG_WINDOW, '1);
    write_reg(CFG_OPEN, '1);
    write_reg(CFG_PARTIAL, 32'd4);
    write_reg(CFG_COMPLETE, 32'd4);
    quiet_mode = 1'b1;
    run_random(350, 20, 10, 0, 0);
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_zero_threshold();
    write_reg(CFG_WINDOW, 32'd1000);
    write_reg(CFG_OPEN, 32'd1);
    write_reg(CFG_PARTIAL, 32'd0);
    write_reg(CFG_COMPLETE, 32'd32);
    run_random(350, 8, 10, 0, 0);
  endtask

  always @(posedge clk_i) begin : alert_check
    chain_alert_t want;
    chain_alert_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (alerts_due.size() == 0) begin
        flag_alert($sformatf("unexpected alert kind=%0d caller=%h target=%h mask=%h count=%0d",
                             got.kind, got.caller, got.target, got.mask, got.count));
      end else begin
        want = alerts_due.pop_front();
        if (got !== want) begin
          flag_alert($sformatf({"alert mismatch: expected kind=%0d caller=%h target=%h ",
                                "mask=%h count=%0d pad=%b, got kind=%0d caller=%h target=%h ",
                                "mask=%h count=%0d pad=%b"},
                               want.kind, want.caller, want.target, want.mask, want.count,
                               want.pad, got.kind, got.caller, got.target, got.mask,
                               got.count, got.pad));
        end
      end
    end
  end

  // receiver side: random stalls plus an occasional long hold on request
  initial begin : alert_sink
    int stall;
    stall         = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall == 0 && !quiet_mode && $urandom_range(0, 2) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ENABLE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    bad_alerts    = 0;
    quiet_mode    = 1'b0;
    rx_hold_req   = 0;
    now_ms        = '0;
    cfg_enable    = 1'b0;
    cfg_window    = WINDOW_RST;
    cfg_open      = OPEN_RST;
    cfg_partial   = PARTIAL_RST;
    cfg_complete  = COMPLETE_RST;
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      chain_live[k] = 1'b0;
      chains[k]     = '0;
    end
    for (int k = 0; k < 48; k++) begin
      chain_callers[k] = $urandom;
      if (chain_callers[k] == '0) chain_callers[k] = 32'd1;
    end
    for (int k = 0; k < 4; k++) chain_targets[k] = $urandom;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_chain_thresholds();
    test_both_at_once();
    test_threshold_extremes();
    test_random_default();
    test_random_crowded_table();
    test_random_no_idle();
    test_random_zero_threshold();

    wait_alerts_drained();
    if (bad_alerts == 0 && alerts_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== injection_chain_tracker.f =====
+incdir+hw/rtl
hw/rtl/ict_pkg.sv
hw/rtl/ict_ram.sv
hw/rtl/ict_ctrl.sv
hw/rtl/ict_datapath.sv
hw/rtl/injection_chain_tracker.sv
tb/sv/tb_top.sv
